FILE: hdl/mi_pkg.sv
// shared constants and controller/datapath interface types for modular_inverse
`default_nettype none

package mi_pkg;

    // default datapath width, operands use one bit less
    localparam int WIDTH_DEF = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture operands and set up the a mod n division
        logic iterate;    // one shift-subtract step of the divider
        logic setup;      // seed remainder chain and coefficients
        logic step_load;  // set up the division r0 / r1 of one euclid step
        logic update;     // advance remainder chain and coefficients
        logic out_load;   // write the result register
    } t_mi_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_last;   // divider is in its final cycle
        logic r1_zero;    // remainder chain has ended
        logic n_small;    // modulus below two
    } t_mi_sts;

endpackage

`default_nettype wire

FILE: hdl/mi_ctrl.sv
// controller state machine for modular_inverse
`default_nettype none

module mi_ctrl
    import mi_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    output t_mi_cmd      o_cmd,
    input  wire t_mi_sts i_sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_STEP   = 3'd4;
    localparam logic [2:0] S_UPDATE = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.iterate = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.n_small || i_sts.r1_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.step_load = 1'b1;
                    n_state         = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.iterate = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_FIN: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: hdl/mi_dp.sv
// datapath for modular_inverse: shift-subtract divider, remainder chain, coefficients
`default_nettype none

module mi_dp
    import mi_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire t_mi_cmd          i_cmd,
    output t_mi_sts               o_sts,
    input  wire logic [WIDTH-2:0] i_modulus,
    input  wire logic [WIDTH-2:0] i_value,
    output logic      [WIDTH-2:0] o_inverse,
    output logic                  o_has_inverse
);

    localparam int OPW = WIDTH - 1;
    localparam int CW  = $clog2(OPW);
    localparam logic [CW-1:0] CNT_LAST = CW'(OPW - 1);

    logic        [OPW-1:0] r_n;
    logic        [OPW-1:0] r_r0;
    logic        [OPW-1:0] r_r1;
    logic signed [OPW:0]   r_t0;
    logic signed [OPW:0]   r_t1;
    logic signed [OPW+1:0] r_acc;
    logic        [OPW-1:0] r_qsh;
    logic        [OPW-1:0] r_rem;
    logic        [OPW-1:0] r_d;
    logic        [CW-1:0]  r_cnt;
    logic        [OPW-1:0] r_inv;
    logic                  r_has;

    logic        [OPW+1:0] w_diff;
    logic                  w_qbit;
    logic        [OPW-1:0] w_rem_next;
    logic signed [OPW+1:0] w_acc_next;
    logic signed [OPW+1:0] w_t_new;
    logic signed [OPW:0]   w_t_fix;
    logic                  w_ok;

    // one restoring division step, quotient bits also accumulate q * t1
    assign w_diff     = {1'b0, r_rem, r_qsh[OPW-1]} - {2'b00, r_d};
    assign w_qbit     = !w_diff[OPW+1];
    assign w_rem_next = w_qbit ? w_diff[OPW-1:0] : {r_rem[OPW-2:0], r_qsh[OPW-1]};
    assign w_acc_next = (r_acc <<< 1) + (w_qbit ? {r_t1[OPW], r_t1} : '0);

    assign w_t_new = {r_t0[OPW], r_t0} - r_acc;
    assign w_t_fix = r_t0[OPW] ? (r_t0 + $signed({1'b0, r_n})) : r_t0;
    assign w_ok    = !o_sts.n_small && (r_r0 == OPW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= i_modulus;
            r_qsh <= i_value;
            r_d   <= i_modulus;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.step_load) begin
            r_qsh <= r_r0;
            r_d   <= r_r1;
            r_rem <= '0;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.iterate) begin
            r_qsh <= {r_qsh[OPW-2:0], w_qbit};
            r_rem <= w_rem_next;
            r_acc <= w_acc_next;
            r_cnt <= r_cnt + CW'(1);
        end

        if (i_cmd.setup) begin
            r_r0 <= r_n;
            r_r1 <= r_rem;
            r_t0 <= '0;
            r_t1 <= (OPW+1)'(1);
        end else if (i_cmd.update) begin
            r_r0 <= r_r1;
            r_r1 <= r_rem;
            r_t0 <= r_t1;
            r_t1 <= w_t_new[OPW:0];
        end

        if (i_cmd.out_load) begin
            r_inv <= w_ok ? w_t_fix[OPW-1:0] : '0;
            r_has <= w_ok;
        end
    end

    assign o_sts.div_last = (r_cnt == CNT_LAST);
    assign o_sts.r1_zero  = (r_r1 == '0);
    assign o_sts.n_small  = (r_n[OPW-1:1] == '0);

    assign o_inverse     = r_inv;
    assign o_has_inverse = r_has;

endmodule

`default_nettype wire

FILE: hdl/modular_inverse.sv
// top level of modular_inverse: inverse of a value modulo a modulus by extended euclid
//
//  channel   dir  tdata                         tuser
//  s_axis    in   modulus, value (low to high)  -
//  m_axis    out  inverse                       has_inverse
//
// an item runs through k euclid steps between its transaction and its result,
// k being up to about 45 for 31-bit operands; each step and the initial
// a mod n reduction run through one shared shift-subtract divider, one
// quotient bit per cycle
// one item is worked on at a time; a new item is taken while a finished result
// still waits in the output register
// reset (i_rst_n low, synchronous) returns the controller to idle and drops
// m_axis_tvalid; a stalled output holds its result and the next item waits
// before its own result is written
`default_nettype none

module modular_inverse
    import mi_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    // modulus [WIDTH-2:0], value [2*WIDTH-3:WIDTH-1], zero fill above
    input  wire logic [((2*(WIDTH-1)+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    // inverse [WIDTH-2:0], zero fill above
    output logic      [((WIDTH-1+7)/8)*8-1:0]             m_axis_tdata,
    // has_inverse [0]
    output logic                                          m_axis_tuser
);

    localparam int OPW    = WIDTH - 1;
    localparam int OUT_TW = ((OPW + 7) / 8) * 8;

    t_mi_cmd          w_cmd;
    t_mi_sts          w_sts;
    logic [OPW-1:0]   w_inverse;

    // sequencing: accept, reduce, euclid steps, result hand-off
    mi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // divider, remainder chain and coefficient registers
    mi_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_modulus     (s_axis_tdata[OPW-1:0]),
        .i_value       (s_axis_tdata[2*OPW-1:OPW]),
        .o_inverse     (w_inverse),
        .o_has_inverse (m_axis_tuser)
    );

    // pad the result to whole bytes
    assign m_axis_tdata = OUT_TW'(w_inverse);

endmodule

`default_nettype wire

FILE: hdl/mi_chk.sv
// port-level checker for modular_inverse and its bind
`default_nettype none

module mi_chk
    import mi_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [((WIDTH-1+7)/8)*8-1:0]      m_axis_tdata,
    input wire logic                              m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one item at a time: input closes right after a transaction
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open after transaction");

    // no inverse means a zero result
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("nonzero inverse without has_inverse");

    // a real inverse is never zero
    a_inv_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata != '0)
        else $error("zero inverse with has_inverse");

endmodule

bind modular_inverse mi_chk #(
    .WIDTH (WIDTH)
) u_mi_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
